@@ hw/rtl/mso_pkg.sv @@
// Shared widths, gain constants, orientation codes and pipeline control types.
`default_nettype none

package mso_pkg;

    localparam int BYTE_W   = 8;
    localparam int AXIS_W   = 16;
    localparam int CFG_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 6 * BYTE_W;
    localparam int OUT_DATA_W = 3 * AXIS_W;

    // magnitude of count * 1000 stays below 2^25
    localparam int MAG_W    = 25;
    localparam int SENS_W   = 11;
    localparam int RECIP_SH = 26;
    localparam int RECIP_W  = 19;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int QUOT_W   = 18;

    // four axis stages plus the remap stage
    localparam int PIPE_STAGES = 5;

    localparam logic [9:0] MILLI = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SELECT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_ORIENTATION = 2'd1;

    localparam logic [CFG_W-1:0] GAIN_RESET   = 3'd1;
    localparam logic [CFG_W-1:0] ORIENT_RESET = 3'd0;

    localparam logic [CFG_W-1:0] ORI_TOP_0    = 3'd0;
    localparam logic [CFG_W-1:0] ORI_TOP_90   = 3'd1;
    localparam logic [CFG_W-1:0] ORI_TOP_180  = 3'd2;
    localparam logic [CFG_W-1:0] ORI_TOP_270  = 3'd3;
    localparam logic [CFG_W-1:0] ORI_BOT_0    = 3'd4;
    localparam logic [CFG_W-1:0] ORI_BOT_90   = 3'd5;
    localparam logic [CFG_W-1:0] ORI_BOT_180  = 3'd6;
    localparam logic [CFG_W-1:0] ORI_BOT_270  = 3'd7;

    localparam int SENS_0 = 1370;
    localparam int SENS_1 = 1090;
    localparam int SENS_2 = 820;
    localparam int SENS_3 = 660;
    localparam int SENS_4 = 440;
    localparam int SENS_5 = 390;
    localparam int SENS_6 = 330;
    localparam int SENS_7 = 230;

    localparam longint RECIP_ONE = longint'(1) << RECIP_SH;
    localparam longint RECIP_0 = RECIP_ONE / SENS_0;
    localparam longint RECIP_1 = RECIP_ONE / SENS_1;
    localparam longint RECIP_2 = RECIP_ONE / SENS_2;
    localparam longint RECIP_3 = RECIP_ONE / SENS_3;
    localparam longint RECIP_4 = RECIP_ONE / SENS_4;
    localparam longint RECIP_5 = RECIP_ONE / SENS_5;
    localparam longint RECIP_6 = RECIP_ONE / SENS_6;
    localparam longint RECIP_7 = RECIP_ONE / SENS_7;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_pipe_ctl;

    function automatic logic [SENS_W-1:0] gain_sens(input logic [CFG_W-1:0] gain);
        logic [SENS_W-1:0] s;
        case (gain)
            3'd0:    s = SENS_W'(SENS_0);
            3'd1:    s = SENS_W'(SENS_1);
            3'd2:    s = SENS_W'(SENS_2);
            3'd3:    s = SENS_W'(SENS_3);
            3'd4:    s = SENS_W'(SENS_4);
            3'd5:    s = SENS_W'(SENS_5);
            3'd6:    s = SENS_W'(SENS_6);
            default: s = SENS_W'(SENS_7);
        endcase
        return s;
    endfunction

    function automatic logic [RECIP_W-1:0] gain_recip(input logic [CFG_W-1:0] gain);
        logic [RECIP_W-1:0] r;
        case (gain)
            3'd0:    r = RECIP_W'(RECIP_0);
            3'd1:    r = RECIP_W'(RECIP_1);
            3'd2:    r = RECIP_W'(RECIP_2);
            3'd3:    r = RECIP_W'(RECIP_3);
            3'd4:    r = RECIP_W'(RECIP_4);
            3'd5:    r = RECIP_W'(RECIP_5);
            3'd6:    r = RECIP_W'(RECIP_6);
            default: r = RECIP_W'(RECIP_7);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mso_axis_scale.sv @@
// One axis: signed count times 1000, divided by the gain sensitivity, wrapped to 16 bits.
`default_nettype none

module mso_axis_scale
    import mso_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_pipe_ctl           i_ctl,
    input  wire logic [BYTE_W-1:0]   i_high,
    input  wire logic [BYTE_W-1:0]   i_low,
    input  wire logic [SENS_W-1:0]   i_sens,
    input  wire logic [RECIP_W-1:0]  i_recip,
    output logic signed [AXIS_W-1:0] o_value
);

    logic [AXIS_W-1:0] raw;
    logic [AXIS_W-1:0] mag;
    logic [MAG_W-1:0]  n_s1_mag;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W+SENS_W-1:0] qd_full;
    logic [MAG_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;

    logic              r_s1_sign;
    logic [MAG_W-1:0]  r_s1_mag;
    logic              r_s2_sign;
    logic [MAG_W-1:0]  r_s2_mag;
    logic [QUOT_W-1:0] r_s2_quot;
    logic              r_s3_sign;
    logic [MAG_W-1:0]  r_s3_mag;
    logic [QUOT_W-1:0] r_s3_quot;
    logic [MAG_W-1:0]  r_s3_qd;
    logic signed [AXIS_W-1:0] r_s4_value;

    always_comb begin
        raw      = {i_high, i_low};
        mag      = raw[AXIS_W-1] ? AXIS_W'(AXIS_W'(0) - raw) : raw;
        n_s1_mag = MAG_W'(MAG_W'(mag) * MAG_W'(MILLI));
        prod     = PROD_W'(r_s1_mag) * PROD_W'(i_recip);
        qd_full  = (QUOT_W+SENS_W)'(r_s2_quot) * (QUOT_W+SENS_W)'(i_sens);
        rem      = r_s3_mag - r_s3_qd;
        quot     = (rem >= MAG_W'(i_sens)) ? QUOT_W'(r_s3_quot + QUOT_W'(1)) : r_s3_quot;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_s1_sign <= raw[AXIS_W-1];
            r_s1_mag  <= n_s1_mag;
        end
        if (i_ctl.ld2) begin
            r_s2_sign <= r_s1_sign;
            r_s2_mag  <= r_s1_mag;
            r_s2_quot <= prod[RECIP_SH+QUOT_W-1:RECIP_SH];
        end
        if (i_ctl.ld3) begin
            r_s3_sign <= r_s2_sign;
            r_s3_mag  <= r_s2_mag;
            r_s3_quot <= r_s2_quot;
            r_s3_qd   <= qd_full[MAG_W-1:0];
        end
        if (i_ctl.ld4) begin
            r_s4_value <= r_s3_sign ? AXIS_W'(QUOT_W'(0) - quot) : quot[AXIS_W-1:0];
        end
    end

    assign o_value = r_s4_value;

endmodule

`default_nettype wire

@@ hw/rtl/mso_orient.sv @@
// Output stage: sign and swap of scaled sensor axes into the body frame.
`default_nettype none

module mso_orient
    import mso_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_load,
    input  wire logic [CFG_W-1:0]    i_orient,
    input  wire logic [AXIS_W-1:0]   i_sx,
    input  wire logic [AXIS_W-1:0]   i_sy,
    input  wire logic [AXIS_W-1:0]   i_sz,
    output logic [OUT_DATA_W-1:0]    o_data
);

    logic [AXIS_W-1:0] nx;
    logic [AXIS_W-1:0] ny;
    logic [AXIS_W-1:0] nz;
    logic [AXIS_W-1:0] n_bx;
    logic [AXIS_W-1:0] n_by;
    logic [AXIS_W-1:0] n_bz;
    logic [AXIS_W-1:0] r_bx;
    logic [AXIS_W-1:0] r_by;
    logic [AXIS_W-1:0] r_bz;

    always_comb begin
        nx = AXIS_W'(AXIS_W'(0) - i_sx);
        ny = AXIS_W'(AXIS_W'(0) - i_sy);
        nz = AXIS_W'(AXIS_W'(0) - i_sz);
        case (i_orient)
            ORI_TOP_0:   begin n_bx = nx;   n_by = i_sy; n_bz = nz;   end
            ORI_TOP_90:  begin n_bx = ny;   n_by = nx;   n_bz = nz;   end
            ORI_TOP_180: begin n_bx = i_sx; n_by = ny;   n_bz = nz;   end
            ORI_TOP_270: begin n_bx = i_sy; n_by = i_sx; n_bz = nz;   end
            ORI_BOT_0:   begin n_bx = nx;   n_by = ny;   n_bz = i_sz; end
            ORI_BOT_90:  begin n_bx = ny;   n_by = i_sx; n_bz = i_sz; end
            ORI_BOT_180: begin n_bx = i_sx; n_by = i_sy; n_bz = i_sz; end
            default:     begin n_bx = i_sy; n_by = nx;   n_bz = i_sz; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bx <= n_bx;
            r_by <= n_by;
            r_bz <= n_bz;
        end
    end

    assign o_data = {r_bz, r_by, r_bx};

endmodule

`default_nettype wire

@@ hw/rtl/magnetometer_scale_and_orient.sv @@
// Top level: config registers, pipeline valid and load control, axis scalers and remap.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | raw bytes x_hi x_lo z_hi z_lo y_hi y_lo
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | body_x body_y body_z, milligauss
//  cfg       | in  | i_cfg_valid / o_cfg_ready      | register index, write data
//
// Five register stages: abs and x1000, reciprocal multiply, back multiply, correct and
// sign, remap. One sample per cycle while the output is not stalled. Each stage loads
// when empty or when the next one moves, so a stalled output holds its sample while
// earlier stages keep filling. Reset empties the pipeline and loads gain 1 and
// orientation 0; config is always ready.
`default_nettype none

module magnetometer_scale_and_orient
    import mso_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // x_high, x_low, z_high, z_low, y_high, y_low (8 bits each)
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // body_x, body_y, body_z (16 bits each, signed)
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0]  r_gain;
    logic [CFG_W-1:0]  r_orient;
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] ld;
    t_pipe_ctl         ctl;
    logic [SENS_W-1:0] sens;
    logic [RECIP_W-1:0] recip;
    logic signed [AXIS_W-1:0] sx;
    logic signed [AXIS_W-1:0] sy;
    logic signed [AXIS_W-1:0] sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_orient <= ORIENT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_GAIN_SELECT) begin
                r_gain <= i_cfg_data[CFG_W-1:0];
            end
            if (i_cfg_index == CFG_MOUNT_ORIENTATION) begin
                r_orient <= i_cfg_data[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        ld[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || m_axis_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        ctl.ld1 = ld[0];
        ctl.ld2 = ld[1];
        ctl.ld3 = ld[2];
        ctl.ld4 = ld[3];
        sens    = gain_sens(r_gain);
        recip   = gain_recip(r_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    mso_axis_scale u_scale_x (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_high  (s_axis_tdata[7:0]),
        .i_low   (s_axis_tdata[15:8]),
        .i_sens  (sens),
        .i_recip (recip),
        .o_value (sx)
    );

    mso_axis_scale u_scale_z (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_high  (s_axis_tdata[23:16]),
        .i_low   (s_axis_tdata[31:24]),
        .i_sens  (sens),
        .i_recip (recip),
        .o_value (sz)
    );

    mso_axis_scale u_scale_y (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_high  (s_axis_tdata[39:32]),
        .i_low   (s_axis_tdata[47:40]),
        .i_sens  (sens),
        .i_recip (recip),
        .o_value (sy)
    );

    mso_orient u_orient (
        .i_clk    (i_clk),
        .i_load   (ld[PIPE_STAGES-1]),
        .i_orient (r_orient),
        .i_sx     (sx),
        .i_sy     (sy),
        .i_sz     (sz),
        .o_data   (m_axis_tdata)
    );

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = r_vld[PIPE_STAGES-1];
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

@@ hw/rtl/mso_checker.sv @@
// Port-level checks on the top level, attached by bind.
`default_nettype none

module mso_checker
    import mso_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("sample did not reach output after five cycles");

endmodule

bind magnetometer_scale_and_orient mso_checker u_mso_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
